// ----- rtl/cgee_pkg.sv -----
package cgee_pkg;

   // Field and register widths
   localparam int DATA_W       = 32;
   localparam int MP_W         = 64;
   localparam int ENERGY_W     = 48;
   localparam int HI_W         = 48;
   localparam int ACC_W        = 112;
   localparam int STEP_LEN_W   = 31;
   localparam int STEPS_W      = 20;
   localparam int LOOK_W       = 7;
   localparam int STEP_COUNT_W = 20;
   localparam int CSR_IDX_W    = 3;
   localparam int STEP_W       = 5;

   // Last step of the evaluation sequence
   localparam logic [STEP_W-1:0] EVAL_LAST = 5'd17;

   // Transaction kinds
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RELATIVE_ACCURACY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MACHINE_EPSILON   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ABSOLUTE_ACCURACY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MINIMAL_ACCURACY  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEPS         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOK_AHEAD        = 3'd5;

   // Register reset values
   localparam logic [DATA_W-1:0]  RST_RELATIVE_ACCURACY = 32'd4295;
   localparam logic [DATA_W-1:0]  RST_MACHINE_EPSILON   = 32'd1;
   localparam logic [DATA_W-1:0]  RST_ABSOLUTE_ACCURACY = 32'd4295;
   localparam logic [DATA_W-1:0]  RST_MINIMAL_ACCURACY  = 32'd429496730;
   localparam logic [STEPS_W-1:0] RST_MAX_STEPS         = 20'd1000;
   localparam logic [LOOK_W-1:0]  RST_LOOK_AHEAD        = 7'd10;

   typedef struct packed {
      logic [DATA_W-1:0]  relative_accuracy;
      logic [DATA_W-1:0]  machine_epsilon;
      logic [DATA_W-1:0]  absolute_accuracy;
      logic [DATA_W-1:0]  minimal_accuracy;
      logic [STEPS_W-1:0] max_steps;
      logic [LOOK_W-1:0]  look_ahead;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRODUCT,
      ST_UPDATE,
      ST_REBUILD,
      ST_CLEAR,
      ST_EVAL,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [2:0] {
      STG_NONE,
      STG_CAPTURE,
      STG_PRODUCT,
      STG_UPDATE,
      STG_CLEAR,
      STG_REBUILD,
      STG_EVAL,
      STG_FINISH
   } stage_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_AR,
      MUL_SQ_TOL,
      MUL_SQ_MIN,
      MUL_SQ_EPS,
      MUL_SQ_ABS,
      MUL_LL,
      MUL_LH,
      MUL_HL,
      MUL_HH
   } mul_op_type;

   typedef enum logic [1:0] {
      SQ_TOL,
      SQ_MIN,
      SQ_EPS
   } sq_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD32,
      ACC_ADD64,
      ACC_TABS
   } acc_op_type;

   typedef enum logic [2:0] {
      LAT_NONE,
      LAT_T2,
      LAT_M2,
      LAT_E2,
      LAT_A2,
      LAT_REL,
      LAT_MIN
   } latch_type;

   typedef struct packed {
      stage_type  stage;
      mul_op_type mul_op;
      sq_sel_type sq_sel;
      acc_op_type acc_op;
      latch_type  latch;
   } cmd_type;

   typedef struct packed {
      logic rebuild_req;
      logic rebuild_done;
      logic out_free;
   } status_type;

   localparam cmd_type CMD_IDLE = '{
      stage:  STG_NONE,
      mul_op: MUL_NONE,
      sq_sel: SQ_TOL,
      acc_op: ACC_HOLD,
      latch:  LAT_NONE
   };

   // Microcode of the evaluation: squares first, then three 64x48 products
   // built from four partial products each, then the vanishing-step threshold.
   function automatic cmd_type eval_cmd(input logic [STEP_W-1:0] step);
      cmd_type cmd;
      cmd       = CMD_IDLE;
      cmd.stage = STG_EVAL;
      unique case (step)
         5'd0: begin
            cmd.mul_op = MUL_SQ_TOL;
         end
         5'd1: begin
            cmd.latch  = LAT_T2;
            cmd.mul_op = MUL_SQ_MIN;
         end
         5'd2: begin
            cmd.latch  = LAT_M2;
            cmd.mul_op = MUL_SQ_EPS;
         end
         5'd3: begin
            cmd.latch  = LAT_E2;
            cmd.mul_op = MUL_SQ_ABS;
         end
         5'd4: begin
            cmd.latch  = LAT_A2;
            cmd.mul_op = MUL_LL;
            cmd.sq_sel = SQ_TOL;
         end
         5'd5: begin
            cmd.acc_op = ACC_LOAD;
            cmd.mul_op = MUL_LH;
            cmd.sq_sel = SQ_TOL;
         end
         5'd6: begin
            cmd.acc_op = ACC_ADD32;
            cmd.mul_op = MUL_HL;
            cmd.sq_sel = SQ_TOL;
         end
         5'd7: begin
            cmd.acc_op = ACC_ADD32;
            cmd.mul_op = MUL_HH;
            cmd.sq_sel = SQ_TOL;
         end
         5'd8: begin
            cmd.acc_op = ACC_ADD64;
            cmd.mul_op = MUL_LL;
            cmd.sq_sel = SQ_MIN;
         end
         5'd9: begin
            cmd.latch  = LAT_REL;
            cmd.acc_op = ACC_LOAD;
            cmd.mul_op = MUL_LH;
            cmd.sq_sel = SQ_MIN;
         end
         5'd10: begin
            cmd.acc_op = ACC_ADD32;
            cmd.mul_op = MUL_HL;
            cmd.sq_sel = SQ_MIN;
         end
         5'd11: begin
            cmd.acc_op = ACC_ADD32;
            cmd.mul_op = MUL_HH;
            cmd.sq_sel = SQ_MIN;
         end
         5'd12: begin
            cmd.acc_op = ACC_ADD64;
            cmd.mul_op = MUL_LL;
            cmd.sq_sel = SQ_EPS;
         end
         5'd13: begin
            cmd.latch  = LAT_MIN;
            cmd.acc_op = ACC_LOAD;
            cmd.mul_op = MUL_LH;
            cmd.sq_sel = SQ_EPS;
         end
         5'd14: begin
            cmd.acc_op = ACC_ADD32;
            cmd.mul_op = MUL_HL;
            cmd.sq_sel = SQ_EPS;
         end
         5'd15: begin
            cmd.acc_op = ACC_ADD32;
            cmd.mul_op = MUL_HH;
            cmd.sq_sel = SQ_EPS;
         end
         5'd16: begin
            cmd.acc_op = ACC_ADD64;
         end
         5'd17: begin
            cmd.acc_op = ACC_TABS;
         end
         default: begin
            cmd.stage = STG_EVAL;
         end
      endcase
      return cmd;
   endfunction

   // value * 2^64 < product, for a 112-bit product
   function automatic logic lt_upper(input logic [HI_W-1:0] value,
                                     input logic [ACC_W-1:0] product);
      logic [HI_W-1:0] hi;
      logic            lo_nz;
      hi    = product[ACC_W-1:MP_W];
      lo_nz = (product[MP_W-1:0] != '0);
      return (value < hi) || ((value == hi) && lo_nz);
   endfunction

endpackage

// ----- rtl/cgee_csr.sv -----
module cgee_csr
   import cgee_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_write_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index; ignore writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RELATIVE_ACCURACY: cfg_in.relative_accuracy = csr_write_data;
            CSR_MACHINE_EPSILON:   cfg_in.machine_epsilon   = csr_write_data;
            CSR_ABSOLUTE_ACCURACY: cfg_in.absolute_accuracy = csr_write_data;
            CSR_MINIMAL_ACCURACY:  cfg_in.minimal_accuracy  = csr_write_data;
            CSR_MAX_STEPS:         cfg_in.max_steps  = csr_write_data[STEPS_W-1:0];
            CSR_LOOK_AHEAD:        cfg_in.look_ahead = csr_write_data[LOOK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.relative_accuracy <= RST_RELATIVE_ACCURACY;
         cfg_ff.machine_epsilon   <= RST_MACHINE_EPSILON;
         cfg_ff.absolute_accuracy <= RST_ABSOLUTE_ACCURACY;
         cfg_ff.minimal_accuracy  <= RST_MINIMAL_ACCURACY;
         cfg_ff.max_steps         <= RST_MAX_STEPS;
         cfg_ff.look_ahead        <= RST_LOOK_AHEAD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/cgee_ctrl.sv -----
module cgee_ctrl
   import cgee_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_type,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   ctrl_state_type     state_ff;
   ctrl_state_type     state_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == REQ_CLEAR) ? ST_CLEAR : ST_PRODUCT;
            end
         end
         ST_PRODUCT: state_in = ST_UPDATE;
         ST_UPDATE:  state_in = status.rebuild_req ? ST_REBUILD : ST_EVAL;
         ST_REBUILD: begin
            if (status.rebuild_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_CLEAR: state_in = ST_EVAL;
         ST_EVAL: begin
            if (step_ff == EVAL_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Advance the evaluation step only while evaluating
   assign step_in = (state_ff == ST_EVAL) ? step_ff + STEP_W'(1) : '0;

   // Outputs
   always_comb begin
      cmd       = CMD_IDLE;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.stage = req_valid ? STG_CAPTURE : STG_NONE;
         end
         ST_PRODUCT: begin
            cmd.stage  = STG_PRODUCT;
            cmd.mul_op = MUL_AR;
         end
         ST_UPDATE:  cmd.stage = STG_UPDATE;
         ST_REBUILD: cmd.stage = STG_REBUILD;
         ST_CLEAR:   cmd.stage = STG_CLEAR;
         ST_EVAL:    cmd = eval_cmd(step_ff);
         ST_FINISH:  cmd.stage = STG_FINISH;
         default:    cmd = CMD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- rtl/cgee_datapath.sv -----
module cgee_datapath
   import cgee_pkg::*;
#(
   parameter int MAX_LOOK_AHEAD = 64,
   parameter int COUNT_BITS     = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  cfg_type                 cfg,
   input  logic [DATA_W-1:0]       req_alpha,
   input  logic [DATA_W-1:0]       req_residual_product,
   input  logic signed [DATA_W-1:0] req_curvature,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_terminate,
   output logic                    rsp_vanishing_step,
   output logic                    rsp_minimal_decrease,
   output logic [STEP_COUNT_W-1:0] rsp_step_count
);

   localparam int PTR_W   = (MAX_LOOK_AHEAD > 1) ? $clog2(MAX_LOOK_AHEAD) : 1;
   localparam int WIN_W   = $clog2(MAX_LOOK_AHEAD + 1);
   localparam int DI_W    = WIN_W + 1;
   localparam int SUM_W   = DATA_W + $clog2(MAX_LOOK_AHEAD);
   localparam int SUM1_W  = SUM_W + 1;
   localparam int WC_W    = (WIN_W > LOOK_W) ? WIN_W : LOOK_W;
   localparam int CMP0_W  = (COUNT_BITS > STEPS_W) ? COUNT_BITS : STEPS_W;
   localparam int CMP_W   = (CMP0_W > WIN_W) ? CMP0_W : WIN_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_LOOK_AHEAD - 1);

   // Captured transaction
   logic [DATA_W-1:0]     alpha_ff, alpha_in;
   logic [DATA_W-1:0]     res_ff, res_in;
   logic [DATA_W-1:0]     curv_ff, curv_in;

   // Solver history state
   logic [PTR_W-1:0]      wp_ff, wp_in;
   logic [PTR_W-1:0]      rp_ff, rp_in;
   logic [WIN_W-1:0]      left_ff, left_in;
   logic                  pend_ff, pend_in;
   logic [SUM_W-1:0]      ws_ff, ws_in;
   logic [ENERGY_W-1:0]   energy_ff, energy_in;
   logic [STEP_LEN_W-1:0] step_ff, step_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [WIN_W-1:0]      sum_win_ff, sum_win_in;

   // Evaluation registers
   logic [MP_W-1:0]       mp_ff, mp_in;
   logic [MP_W-1:0]       t2_ff, t2_in;
   logic [MP_W-1:0]       m2_ff, m2_in;
   logic [MP_W-1:0]       e2_ff, e2_in;
   logic [MP_W-1:0]       a2_ff, a2_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic                  flag_rel_ff, flag_rel_in;
   logic                  flag_min_ff, flag_min_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    term_ff, term_in;
   logic                    vanish_ff, vanish_in;
   logic                    mindec_ff, mindec_in;
   logic [STEP_COUNT_W-1:0] count_out_ff, count_out_in;

   // History memory
   logic [DATA_W-1:0]     history_mem [MAX_LOOK_AHEAD];
   logic [DATA_W-1:0]     rd_data_ff;
   logic [PTR_W-1:0]      rd_addr;
   logic                  mem_re;
   logic                  mem_we;

   // Combinational helpers
   logic [WC_W-1:0]       la_ext;
   logic [WC_W-1:0]       win_wide;
   logic [WIN_W-1:0]      win;
   logic [DATA_W-1:0]     tol;
   logic [MP_W-1:0]       sq_val;
   logic [DATA_W-1:0]     mul_a;
   logic [DATA_W-1:0]     mul_b;
   logic [DATA_W-1:0]     e_lo;
   logic [DATA_W-1:0]     e_hi;
   logic [DATA_W-1:0]     prod;
   logic [DI_W-1:0]       di_sum;
   logic [PTR_W-1:0]      drop_idx;
   logic [PTR_W-1:0]      rp_dec;
   logic [PTR_W-1:0]      wp_inc;
   logic [COUNT_BITS-1:0] count_new;
   logic [WIN_W-1:0]      n_win;
   logic                  drop;
   logic [SUM1_W-1:0]     ws_inc;
   logic [ENERGY_W:0]     esum;
   logic [DATA_W-1:0]     mag;
   logic [ACC_W-1:0]      t80;
   logic                  use_cand;
   logic                  out_free;
   logic [CMP_W-1:0]      count_cmp;
   logic [CMP_W-1:0]      win_cmp;

   // Effective window length: zero acts as one, clamp to the ring depth
   assign la_ext   = WC_W'(cfg.look_ahead);
   assign win_wide = (la_ext == '0) ? WC_W'(1) :
                     (la_ext > WC_W'(MAX_LOOK_AHEAD)) ? WC_W'(MAX_LOOK_AHEAD) : la_ext;
   assign win      = WIN_W'(win_wide);

   assign tol  = (cfg.relative_accuracy > cfg.machine_epsilon) ?
                 cfg.relative_accuracy : cfg.machine_epsilon;
   assign e_lo = energy_ff[DATA_W-1:0];
   assign e_hi = DATA_W'(energy_ff[ENERGY_W-1:DATA_W]);

   // Select the square being multiplied by the energy
   always_comb begin
      unique case (cmd.sq_sel)
         SQ_TOL:  sq_val = t2_ff;
         SQ_MIN:  sq_val = m2_ff;
         SQ_EPS:  sq_val = e2_ff;
         default: sq_val = t2_ff;
      endcase
   end

   // Shared multiplier operands
   always_comb begin
      unique case (cmd.mul_op)
         MUL_AR: begin
            mul_a = alpha_ff;
            mul_b = res_ff;
         end
         MUL_SQ_TOL: begin
            mul_a = tol;
            mul_b = tol;
         end
         MUL_SQ_MIN: begin
            mul_a = cfg.minimal_accuracy;
            mul_b = cfg.minimal_accuracy;
         end
         MUL_SQ_EPS: begin
            mul_a = cfg.machine_epsilon;
            mul_b = cfg.machine_epsilon;
         end
         MUL_SQ_ABS: begin
            mul_a = cfg.absolute_accuracy;
            mul_b = cfg.absolute_accuracy;
         end
         MUL_LL: begin
            mul_a = sq_val[DATA_W-1:0];
            mul_b = e_lo;
         end
         MUL_LH: begin
            mul_a = sq_val[DATA_W-1:0];
            mul_b = e_hi;
         end
         MUL_HL: begin
            mul_a = sq_val[MP_W-1:DATA_W];
            mul_b = e_lo;
         end
         MUL_HH: begin
            mul_a = sq_val[MP_W-1:DATA_W];
            mul_b = e_hi;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mp_in = MP_W'(mul_a) * MP_W'(mul_b);

   // Scaled product, truncated to Q16.16 and saturated
   assign prod = (mp_ff[MP_W-1:48] != '0) ? '1 : mp_ff[47:16];

   // Ring pointer arithmetic
   assign di_sum   = (DI_W'(wp_ff) >= DI_W'(win)) ?
                     DI_W'(wp_ff) - DI_W'(win) :
                     DI_W'(wp_ff) + DI_W'(MAX_LOOK_AHEAD) - DI_W'(win);
   assign drop_idx = PTR_W'(di_sum);
   assign rp_dec   = (rp_ff == '0) ? PTR_LAST : rp_ff - PTR_W'(1);
   assign wp_inc   = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);

   // Update arithmetic
   assign count_new = (count_ff == '1) ? count_ff : count_ff + COUNT_BITS'(1);
   assign n_win     = (CMP_W'(count_new) < CMP_W'(win)) ? WIN_W'(count_new) : win;
   assign drop      = (CMP_W'(count_ff) >= CMP_W'(win));
   assign ws_inc    = SUM1_W'(ws_ff) + SUM1_W'(prod) -
                      (drop ? SUM1_W'(rd_data_ff) : SUM1_W'(0));
   assign esum      = (ENERGY_W + 1)'(energy_ff) + (ENERGY_W + 1)'(prod);
   assign mag       = curv_ff[DATA_W-1] ? (~curv_ff + DATA_W'(1)) : curv_ff;

   // Memory ports
   assign mem_we  = (cmd.stage == STG_UPDATE);
   assign mem_re  = (cmd.stage == STG_PRODUCT) ||
                    ((cmd.stage == STG_REBUILD) && (left_ff != '0));
   assign rd_addr = (cmd.stage == STG_REBUILD) ? rp_dec : drop_idx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         history_mem[wp_ff] <= prod;
      end
      if (mem_re) begin
         rd_data_ff <= history_mem[rd_addr];
      end
   end

   // History state: capture, update, rebuild, clear
   always_comb begin
      alpha_in   = alpha_ff;
      res_in     = res_ff;
      curv_in    = curv_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      left_in    = left_ff;
      pend_in    = pend_ff;
      ws_in      = ws_ff;
      energy_in  = energy_ff;
      step_in    = step_ff;
      count_in   = count_ff;
      sum_win_in = sum_win_ff;
      unique case (cmd.stage)
         STG_CAPTURE: begin
            alpha_in = req_alpha;
            res_in   = req_residual_product;
            curv_in  = $unsigned(req_curvature);
         end
         STG_UPDATE: begin
            wp_in     = wp_inc;
            rp_in     = wp_ff;
            pend_in   = 1'b0;
            energy_in = esum[ENERGY_W] ? '1 : esum[ENERGY_W-1:0];
            step_in   = mag[DATA_W-1] ? '1 : mag[STEP_LEN_W-1:0];
            count_in  = count_new;
            if (sum_win_ff == win) begin
               ws_in   = SUM_W'(ws_inc);
               left_in = '0;
            end else begin
               // window length changed: restart the sum from the new product
               ws_in      = SUM_W'(prod);
               left_in    = n_win - WIN_W'(1);
               sum_win_in = win;
            end
         end
         STG_REBUILD: begin
            if (left_ff != '0) begin
               left_in = left_ff - WIN_W'(1);
               rp_in   = rp_dec;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               ws_in = ws_ff + SUM_W'(rd_data_ff);
            end
         end
         STG_CLEAR: begin
            wp_in      = '0;
            count_in   = '0;
            ws_in      = '0;
            energy_in  = '0;
            left_in    = '0;
            pend_in    = 1'b0;
            sum_win_in = win;
         end
         default: ;
      endcase
   end

   // Latch squares and comparison flags
   always_comb begin
      t2_in       = t2_ff;
      m2_in       = m2_ff;
      e2_in       = e2_ff;
      a2_in       = a2_ff;
      flag_rel_in = flag_rel_ff;
      flag_min_in = flag_min_ff;
      unique case (cmd.latch)
         LAT_T2:  t2_in = mp_ff;
         LAT_M2:  m2_in = mp_ff;
         LAT_E2:  e2_in = mp_ff;
         LAT_A2:  a2_in = mp_ff;
         LAT_REL: flag_rel_in = lt_upper(HI_W'(ws_ff), acc_ff);
         LAT_MIN: flag_min_in = lt_upper(HI_W'(ws_ff), acc_ff);
         default: ;
      endcase
   end

   // Vanishing-step threshold: absolute tolerance, lowered to the scaled one
   assign t80      = ACC_W'({a2_ff, 16'b0});
   assign use_cand = (ENERGY_W'(a2_ff[MP_W-1:48]) < energy_ff) && (acc_ff < t80);

   // Accumulate partial products
   always_comb begin
      unique case (cmd.acc_op)
         ACC_HOLD:  acc_in = acc_ff;
         ACC_LOAD:  acc_in = ACC_W'(mp_ff);
         ACC_ADD32: acc_in = acc_ff + (ACC_W'(mp_ff) << 32);
         ACC_ADD64: acc_in = acc_ff + (ACC_W'(mp_ff) << 64);
         ACC_TABS:  acc_in = use_cand ? acc_ff : t80;
         default:   acc_in = acc_ff;
      endcase
   end

   // Result register
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign count_cmp = CMP_W'(count_ff);
   assign win_cmp   = CMP_W'(win);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      term_in      = term_ff;
      vanish_in    = vanish_ff;
      mindec_in    = mindec_ff;
      count_out_in = count_out_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((cmd.stage == STG_FINISH) && out_free) begin
         rsp_valid_in = 1'b1;
         term_in      = (count_cmp > CMP_W'(cfg.max_steps)) ||
                        ((count_cmp > win_cmp) && flag_rel_ff);
         vanish_in    = lt_upper(HI_W'(step_ff), acc_ff);
         mindec_in    = (count_cmp >= win_cmp) && flag_min_ff;
         count_out_in = STEP_COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         ws_ff        <= '0;
         energy_ff    <= '0;
         step_ff      <= '0;
         count_ff     <= '0;
         sum_win_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         ws_ff        <= ws_in;
         energy_ff    <= energy_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         sum_win_ff   <= sum_win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      alpha_ff     <= alpha_in;
      res_ff       <= res_in;
      curv_ff      <= curv_in;
      mp_ff        <= mp_in;
      t2_ff        <= t2_in;
      m2_ff        <= m2_in;
      e2_ff        <= e2_in;
      a2_ff        <= a2_in;
      acc_ff       <= acc_in;
      flag_rel_ff  <= flag_rel_in;
      flag_min_ff  <= flag_min_in;
      term_ff      <= term_in;
      vanish_ff    <= vanish_in;
      mindec_ff    <= mindec_in;
      count_out_ff <= count_out_in;
   end

   assign status.rebuild_req  = (sum_win_ff != win);
   assign status.rebuild_done = (left_ff == '0) && !pend_ff;
   assign status.out_free     = out_free;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_terminate        = term_ff;
   assign rsp_vanishing_step   = vanish_ff;
   assign rsp_minimal_decrease = mindec_ff;
   assign rsp_step_count       = count_out_ff;

endmodule

// ----- rtl/cg_energy_error_termination_unit.sv -----
// Termination test for a conjugate-gradient solver based on the windowed
// energy-error estimate. Each update transaction pushes alpha times the
// residual product into a ring of MAX_LOOK_AHEAD entries, adds it to the
// saturating 48-bit energy and keeps the sum over the last look_ahead
// products; a clear transaction empties the history. Every transaction gives
// one result: terminate, vanishing_step, minimal_decrease and the step count.
// Only one transaction is in flight at a time: req_stall stays high after
// acceptance until the result is loaded into the output register. The
// sequence runs on the single 32x32 multiplier, which forms the product,
// the four tolerance squares and three 64x48 products from four partials
// each. When look_ahead differs from the length the running sum was built
// with, the first update after the change re-reads the window from the
// history memory, one entry a cycle. The history memory needs no clearing
// pass after reset. A finished result waits in an output register while
// the next transaction is accepted.
module cg_energy_error_termination_unit
   import cgee_pkg::*;
#(
   parameter int MAX_LOOK_AHEAD = 64,
   parameter int COUNT_BITS     = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_type,
   input  logic [DATA_W-1:0]        req_alpha,
   input  logic [DATA_W-1:0]        req_residual_product,
   input  logic signed [DATA_W-1:0] req_curvature,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_terminate,
   output logic                     rsp_vanishing_step,
   output logic                     rsp_minimal_decrease,
   output logic [STEP_COUNT_W-1:0]  rsp_step_count,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_write_data
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // Configuration registers
   cgee_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Sequencer
   cgee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // History, multiplier and result register
   cgee_datapath #(
      .MAX_LOOK_AHEAD (MAX_LOOK_AHEAD),
      .COUNT_BITS     (COUNT_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .cfg                  (cfg),
      .req_alpha            (req_alpha),
      .req_residual_product (req_residual_product),
      .req_curvature        (req_curvature),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_terminate        (rsp_terminate),
      .rsp_vanishing_step   (rsp_vanishing_step),
      .rsp_minimal_decrease (rsp_minimal_decrease),
      .rsp_step_count       (rsp_step_count)
   );

endmodule
